// ----- sv/bqt_pkg.sv -----
// ----------------------------------------------------------------------------
// bqt_pkg
// Shared constants, types and weight table for the biquadratic patch
// tessellator.
// ----------------------------------------------------------------------------
`default_nettype none

package bqt_pkg;

  localparam int LEVEL  = 5;
  localparam int NPTS   = 9;
  localparam int NATTR  = 10;
  localparam int ATTR_W = 32;
  localparam int PT_W   = NATTR * ATTR_W;
  localparam int ADDR_W = 4;
  localparam int LVL_W  = $clog2(LEVEL + 1);
  localparam int VIDX_W = 6;
  localparam int WGT_W  = 17;
  localparam int PROD_W = ATTR_W + WGT_W + 1;
  localparam int SHF_W  = PROD_W - 16;
  localparam int ACC_W  = SHF_W + 2;
  localparam int DEN    = LEVEL * LEVEL;
  localparam int ONE_Q  = 131072;

  localparam logic [ADDR_W-1:0] LAST_PT = ADDR_W'(NPTS - 1);

  typedef logic signed [ATTR_W-1:0] attr_t;

  typedef logic [2:0][LEVEL:0][WGT_W-1:0] wgt_tbl_t;

  // One blend term issued by the controller.
  typedef struct packed {
    logic              valid;
    logic              src_tmp;   // operand from row results, else from store
    logic [1:0]        row;       // row result read (column) or written (row)
    logic [ADDR_W-1:0] addr;      // store address
    logic [WGT_W-1:0]  wgt;
    logic              first;
    logic              last;
    logic              to_out;    // result goes to the output register
    logic [VIDX_W-1:0] vidx;
    logic              last_vtx;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic out_valid;
  } stat_t;

  // Q1.16 weights k (0: b^2, 1: 2ab, 2: a^2) for every step t of LEVEL,
  // rounded; evaluated once at elaboration.
  function automatic wgt_tbl_t build_wgt();
    wgt_tbl_t tbl;
    int s;
    int n;
    tbl = '0;
    for (int k = 0; k < 3; k++) begin
      for (int t = 0; t <= LEVEL; t++) begin
        s = LEVEL - t;
        case (k)
          0:       n = s * s;
          1:       n = 2 * s * t;
          default: n = t * t;
        endcase
        tbl[k][t] = WGT_W'((n * ONE_Q + DEN) / (2 * DEN));
      end
    end
    return tbl;
  endfunction

  localparam wgt_tbl_t WGT_TBL = build_wgt();

  // Table lookup of weight k at step t.
  function automatic logic [WGT_W-1:0] weight_f(input logic [1:0] k,
                                                input logic [LVL_W-1:0] t);
    return WGT_TBL[k][t];
  endfunction

endpackage

`default_nettype wire

// ----- sv/bqt_ram.sv -----
// ----------------------------------------------------------------------------
// bqt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bqt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/bqt_ctrl.sv -----
// ----------------------------------------------------------------------------
// bqt_ctrl
// Sequencer: issues row-blend terms for every grid row and column-blend terms for every vertex.
// ----------------------------------------------------------------------------
`default_nettype none

module bqt_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic [bqt_pkg::ADDR_W-1:0] point_index,
  output      logic                       in_stall,
  input  wire bqt_pkg::stat_t             stat,
  output      bqt_pkg::cmd_t              cmd
);

  typedef enum logic [1:0] {S_IDLE, S_ROW, S_COL, S_WAIT} state_t;

  state_t                      state;
  state_t                      ret;
  logic [1:0]                  r;
  logic [1:0]                  c;
  logic [bqt_pkg::LVL_W-1:0]   i;
  logic [bqt_pkg::LVL_W-1:0]   j;
  logic [bqt_pkg::VIDX_W-1:0]  vidx;

  localparam logic [bqt_pkg::LVL_W-1:0] LVL_MAX = bqt_pkg::LVL_W'(bqt_pkg::LEVEL);

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.vidx     = vidx;
    cmd.last_vtx = (i == LVL_MAX) && (j == LVL_MAX);
    case (state)
      S_ROW: begin
        cmd.valid = 1'b1;
        cmd.row   = r;
        cmd.addr  = bqt_pkg::ADDR_W'(r) * bqt_pkg::ADDR_W'(3) + bqt_pkg::ADDR_W'(c);
        cmd.wgt   = bqt_pkg::weight_f(c, i);
        cmd.first = (c == 2'd0);
        cmd.last  = (c == 2'd2);
      end
      S_COL: begin
        cmd.valid   = 1'b1;
        cmd.src_tmp = 1'b1;
        cmd.row     = r;
        cmd.wgt     = bqt_pkg::weight_f(r, j);
        cmd.first   = (r == 2'd0);
        cmd.last    = (r == 2'd2);
        cmd.to_out  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      r     <= '0;
      c     <= '0;
      i     <= '0;
      j     <= '0;
      vidx  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && point_index == bqt_pkg::LAST_PT) begin
            state <= S_ROW;
            r     <= '0;
            c     <= '0;
            i     <= '0;
            j     <= '0;
            vidx  <= '0;
          end
        end
        S_ROW: begin
          if (c == 2'd2) begin
            c <= '0;
            if (r == 2'd2) begin
              r     <= '0;
              j     <= '0;
              ret   <= S_COL;
              state <= S_WAIT;
            end else begin
              r <= r + 2'd1;
            end
          end else begin
            c <= c + 2'd1;
          end
        end
        S_COL: begin
          if (r == 2'd2) begin
            r     <= '0;
            vidx  <= vidx + 1'b1;
            state <= S_WAIT;
            if (j != LVL_MAX) begin
              j   <= j + 1'b1;
              ret <= S_COL;
            end else if (i != LVL_MAX) begin
              i   <= i + 1'b1;
              ret <= S_ROW;
            end else begin
              ret <= S_IDLE;
            end
          end else begin
            r <= r + 2'd1;
          end
        end
        S_WAIT: begin
          // column terms may only start once the output register is free
          if (!stat.busy && (!stat.out_valid || ret != S_COL)) begin
            state <= ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/bqt_dp.sv -----
// ----------------------------------------------------------------------------
// bqt_dp
// Datapath: control-point store, ten multiply lanes, accumulators, row
// results and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bqt_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        wr_en,
  input  wire logic [bqt_pkg::ADDR_W-1:0]  wr_addr,
  input  wire logic [bqt_pkg::PT_W-1:0]    wr_data,
  input  wire bqt_pkg::cmd_t               cmd,
  input  wire logic                        out_stall,
  output      bqt_pkg::stat_t              stat,
  output      bqt_pkg::attr_t              out_attr [bqt_pkg::NATTR],
  output      logic [bqt_pkg::VIDX_W-1:0]  out_vidx,
  output      logic                        out_last
);

  localparam logic signed [bqt_pkg::ACC_W-1:0] SAT_MAX =
    bqt_pkg::ACC_W'(64'sd2147483647);
  localparam logic signed [bqt_pkg::ACC_W-1:0] SAT_MIN =
    bqt_pkg::ACC_W'(-64'sd2147483648);

  logic [bqt_pkg::PT_W-1:0]             rd_data;
  bqt_pkg::cmd_t                        cmd_s1;
  bqt_pkg::cmd_t                        cmd_s2;
  logic signed [bqt_pkg::PROD_W-1:0]    prod     [bqt_pkg::NATTR];
  logic signed [bqt_pkg::ACC_W-1:0]     acc      [bqt_pkg::NATTR];
  logic signed [bqt_pkg::ACC_W-1:0]     acc_next [bqt_pkg::NATTR];
  bqt_pkg::attr_t                       sat      [bqt_pkg::NATTR];
  bqt_pkg::attr_t                       tmp      [3][bqt_pkg::NATTR];
  bqt_pkg::attr_t                       opnd     [bqt_pkg::NATTR];
  logic                                 ovalid;

  bqt_ram #(.WIDTH(bqt_pkg::PT_W), .DEPTH(bqt_pkg::NPTS)) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (cmd.addr),
    .rdata (rd_data)
  );

  always_comb begin
    for (int a = 0; a < bqt_pkg::NATTR; a++) begin
      opnd[a] = cmd_s1.src_tmp ? tmp[cmd_s1.row][a]
                               : rd_data[a*bqt_pkg::ATTR_W +: bqt_pkg::ATTR_W];
      // product >>> 16, sign-extended into the accumulator
      acc_next[a] = (cmd_s2.first ? '0 : acc[a])
                  + bqt_pkg::ACC_W'($signed(prod[a][bqt_pkg::PROD_W-1:16]));
      if (acc_next[a] > SAT_MAX) begin
        sat[a] = SAT_MAX[bqt_pkg::ATTR_W-1:0];
      end else if (acc_next[a] < SAT_MIN) begin
        sat[a] = SAT_MIN[bqt_pkg::ATTR_W-1:0];
      end else begin
        sat[a] = acc_next[a][bqt_pkg::ATTR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < bqt_pkg::NATTR; a++) begin
      prod[a] <= opnd[a] * $signed({1'b0, cmd_s1.wgt});
      acc[a]  <= acc_next[a];
    end
    if (cmd_s2.valid && cmd_s2.last) begin
      if (cmd_s2.to_out) begin
        out_attr <= sat;
        out_vidx <= cmd_s2.vidx;
        out_last <= cmd_s2.last_vtx;
      end else begin
        tmp[cmd_s2.row] <= sat;
      end
    end
    if (rst) begin
      cmd_s1 <= '0;
      cmd_s2 <= '0;
      ovalid <= 1'b0;
    end else begin
      cmd_s1 <= cmd;
      cmd_s2 <= cmd_s1;
      if (cmd_s2.valid && cmd_s2.last && cmd_s2.to_out) begin
        ovalid <= 1'b1;
      end else if (!out_stall) begin
        ovalid <= 1'b0;
      end
    end
  end

  assign stat.busy      = cmd_s1.valid | cmd_s2.valid;
  assign stat.out_valid = ovalid;

endmodule

`default_nettype wire

// ----- sv/biquadratic_bezier_tessellator.sv -----
// ----------------------------------------------------------------------------
// biquadratic_bezier_tessellator
// Loads the nine control points of a 3x3 biquadratic Bezier patch and emits
// the (LEVEL+1)^2 tessellated vertices when point 8 arrives.
// ----------------------------------------------------------------------------
// Usage and timing: loads of points 0..7 are taken while in_stall is low. A
// load of point 8 starts tessellation and holds in_stall high until every
// blend term has been issued and has left the multiply/accumulate pipeline.
// Each grid row is blended from the nine stored points, one stored point read
// per cycle from the control store's single read port, all ten attributes in
// parallel; the row results then drain from the pipeline. Each vertex is then
// blended from the three row results, after which the multiply/accumulate
// pipeline drains and the output register must empty before the column
// blending of the next vertex starts; a stalled output holds that back. The
// final vertex may still sit in the output register when in_stall drops; new
// loads are taken meanwhile. Loads with point_index 9..15 are dropped.
// Points must all have been loaded before point 8 triggers output.
// ----------------------------------------------------------------------------
`default_nettype none

module biquadratic_bezier_tessellator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input transactions
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic [3:0]                  point_index,
  input  wire logic signed [31:0]          pos_x,
  input  wire logic signed [31:0]          pos_y,
  input  wire logic signed [31:0]          pos_z,
  input  wire logic signed [31:0]          tex_u,
  input  wire logic signed [31:0]          tex_v,
  input  wire logic signed [31:0]          light_u,
  input  wire logic signed [31:0]          light_v,
  input  wire logic signed [31:0]          norm_x,
  input  wire logic signed [31:0]          norm_y,
  input  wire logic signed [31:0]          norm_z,
  // output transactions
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      logic [5:0]                  vertex_index,
  output      logic signed [31:0]          out_pos_x,
  output      logic signed [31:0]          out_pos_y,
  output      logic signed [31:0]          out_pos_z,
  output      logic signed [31:0]          out_tex_u,
  output      logic signed [31:0]          out_tex_v,
  output      logic signed [31:0]          out_light_u,
  output      logic signed [31:0]          out_light_v,
  output      logic signed [31:0]          out_norm_x,
  output      logic signed [31:0]          out_norm_y,
  output      logic signed [31:0]          out_norm_z,
  output      logic                        last_vertex
);

  bqt_pkg::cmd_t   cmd;
  bqt_pkg::stat_t  stat;
  bqt_pkg::attr_t  out_attr [bqt_pkg::NATTR];
  logic            in_take;
  logic            wr_en;

  // a load is a transaction; only indexes 0..8 touch the store
  assign in_take = in_valid && !in_stall;
  assign wr_en   = in_take && (point_index <= bqt_pkg::LAST_PT);

  bqt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_take),
    .point_index (point_index),
    .in_stall    (in_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  // attributes are packed lowest lane first, in field order
  bqt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (point_index),
    .wr_data   ({norm_z, norm_y, norm_x, light_v, light_u,
                 tex_v, tex_u, pos_z, pos_y, pos_x}),
    .cmd       (cmd),
    .out_stall (out_stall),
    .stat      (stat),
    .out_attr  (out_attr),
    .out_vidx  (vertex_index),
    .out_last  (last_vertex)
  );

  assign out_valid   = stat.out_valid;
  assign out_pos_x   = out_attr[0];
  assign out_pos_y   = out_attr[1];
  assign out_pos_z   = out_attr[2];
  assign out_tex_u   = out_attr[3];
  assign out_tex_v   = out_attr[4];
  assign out_light_u = out_attr[5];
  assign out_light_v = out_attr[6];
  assign out_norm_x  = out_attr[7];
  assign out_norm_y  = out_attr[8];
  assign out_norm_z  = out_attr[9];

endmodule

`default_nettype wire

// ----- sv/bqt_checker.sv -----
// ----------------------------------------------------------------------------
// bqt_checker
// Port-level checks for the tessellator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bqt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [3:0]  point_index,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [5:0]  vertex_index,
  input wire logic [31:0] out_pos_x,
  input wire logic        last_vertex
);

  localparam logic [5:0] LAST_VIDX =
    6'((bqt_pkg::LEVEL + 1) * (bqt_pkg::LEVEL + 1) - 1);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_pos_x) && $stable(vertex_index))
    else $error("stalled output payload changed");

  a_trigger: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && point_index == bqt_pkg::LAST_PT |=> in_stall)
    else $error("point 8 did not start tessellation");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_vertex |-> vertex_index == LAST_VIDX)
    else $error("last vertex flag on wrong vertex");

endmodule

bind biquadratic_bezier_tessellator bqt_checker u_bqt_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .point_index  (point_index),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .vertex_index (vertex_index),
  .out_pos_x    (out_pos_x),
  .last_vertex  (last_vertex)
);

`default_nettype wire
